// ----- rtl/core/dmars_pkg.sv -----
// ----------------------------------------------------------------------------
// dmars_pkg
// Shared types, register indexes and helper functions of the dma request
// splitter.
// ----------------------------------------------------------------------------
package dmars_pkg;

  localparam int unsigned LenW   = 13;
  localparam int unsigned AddrW  = 64;
  localparam int unsigned DwW    = 11;
  localparam int unsigned MaxDesc = 32;

  // configuration register indexes
  localparam logic CFG_MAX_READ  = 1'b0;
  localparam logic CFG_MAX_WRITE = 1'b1;

  localparam logic [LenW-1:0] MaxReadReset  = 13'd512;
  localparam logic [LenW-1:0] MaxWriteReset = 13'd128;
  localparam logic [LenW-1:0] ChunkMin      = 13'd4;
  localparam logic [LenW-1:0] ChunkMax      = 13'd4096;
  localparam logic [3:0]      BeFull        = 4'hF;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // latch a new request
    logic emit;   // produce one descriptor into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic final_desc;  // the next descriptor ends the request
  } status_t;

  // chunk size actually used for a register value
  function automatic logic [LenW-1:0] eff_chunk(input logic [LenW-1:0] reg_val);
    logic [LenW-1:0] v;
    v = reg_val & 13'h1FFC;
    if (v < ChunkMin) v = ChunkMin;
    if (v > ChunkMax) v = ChunkMax;
    return v;
  endfunction

  // byte enables of the last dword of a chunk, from the low two size bits
  function automatic logic [3:0] tail_be(input logic [1:0] size_lo);
    logic [3:0] be;
    unique case (size_lo)
      2'd0: be = 4'hF;
      2'd1: be = 4'h1;
      2'd2: be = 4'h3;
      2'd3: be = 4'h7;
      default: be = 4'hF;
    endcase
    return be;
  endfunction

endpackage

// ----- rtl/core/dmars_ctrl.sv -----
// ----------------------------------------------------------------------------
// dmars_ctrl
// Controller of the dma request splitter: accepts a request, then steps the
// datapath once per free output slot until the final descriptor is out.
// ----------------------------------------------------------------------------
module dmars_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  output logic               desc_valid,
  input  logic               desc_ready,
  output dmars_pkg::cmd_t    cmd,
  input  dmars_pkg::status_t status
);
  import dmars_pkg::*;

  state_t state, state_next;
  logic   desc_valid_next;
  logic   slot_free;

  assign slot_free = !desc_valid || desc_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      desc_valid <= 1'b0;
    end else begin
      state      <= state_next;
      desc_valid <= desc_valid_next;
    end
  end

  always_comb begin
    state_next      = state;
    req_ready       = 1'b0;
    cmd             = '0;
    desc_valid_next = desc_valid && !desc_ready;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd.emit        = 1'b1;
          desc_valid_next = 1'b1;
          if (status.final_desc) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  // never overwrite a beat that is still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!desc_valid || desc_ready))
    else $error("descriptor emitted over a pending beat");

  // a loaded request always starts emitting
  a_load_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_EMIT))
    else $error("load did not enter emit");

  // final descriptor returns to idle
  a_final_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && status.final_desc) |=> (state == ST_IDLE && desc_valid))
    else $error("final descriptor did not close the request");

  // an emitted descriptor is offered on the next cycle
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> desc_valid)
    else $error("emitted descriptor not valid");
`endif

endmodule

// ----- rtl/core/dmars_dp.sv -----
// ----------------------------------------------------------------------------
// dmars_dp
// Datapath of the dma request splitter: config registers, request holding
// registers, remaining length and address counters, descriptor register.
// ----------------------------------------------------------------------------
module dmars_dp #(
  parameter int unsigned MAX_LENGTH = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [dmars_pkg::LenW-1:0]    cfg_data,
  input  dmars_pkg::cmd_t               cmd,
  output dmars_pkg::status_t            status,
  input  logic                          req_type,
  input  logic [dmars_pkg::LenW-1:0]    byte_length,
  input  logic [dmars_pkg::AddrW-1:0]   start_address,
  input  logic [15:0]                   req_id,
  input  logic [7:0]                    tag,
  input  logic                          translated,
  output logic                          is_write,
  output logic                          addr_translated,
  output logic [dmars_pkg::DwW-1:0]     dword_count,
  output logic [3:0]                    first_be,
  output logic [3:0]                    last_be,
  output logic [dmars_pkg::AddrW-1:0]   chunk_address,
  output logic [15:0]                   out_req_id,
  output logic [7:0]                    out_tag,
  output logic                          last,
  output logic                          rejected
);
  import dmars_pkg::*;

  localparam logic [LenW:0] MaxLen = (LenW+1)'(MAX_LENGTH);

  logic [LenW-1:0]  max_read, max_write;
  logic             req_wr, req_trans, bad;
  logic [15:0]      rid;
  logic [7:0]       tg;
  logic [AddrW-1:0] addr;
  logic [LenW-1:0]  rem, chunk;

  logic [LenW-1:0]  ld_chunk, size;
  logic [LenW+4:0]  chunk_span;
  logic             ld_bad, fin;
  logic [DwW-1:0]   dw;
  logic [3:0]       be;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_read  <= MaxReadReset;
      max_write <= MaxWriteReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_READ:  max_read  <= cfg_data;
        CFG_MAX_WRITE: max_write <= cfg_data;
        default: ;
      endcase
    end
  end

  // checks on a new request; more than 32 chunks iff length > 32 * chunk
  always_comb begin
    ld_chunk   = eff_chunk(req_type ? max_write : max_read);
    chunk_span = {ld_chunk, 5'b0};
    ld_bad     = (byte_length == '0) || ({1'b0, byte_length} > MaxLen) ||
                 ({5'b0, byte_length} > chunk_span);
  end

  // one chunk step
  always_comb begin
    fin  = (rem <= chunk);
    size = fin ? rem : chunk;
    dw   = DwW'((size + LenW'(3)) >> 2);
    be   = tail_be(size[1:0]);
  end

  assign status.final_desc = bad || fin;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_wr    <= req_type;
      req_trans <= req_type ? 1'b0 : translated;
      rid       <= req_id;
      tg        <= tag;
      addr      <= start_address;
      rem       <= byte_length;
      chunk     <= ld_chunk;
      bad       <= ld_bad;
    end else if (cmd.emit) begin
      rem  <= rem - size;
      addr <= addr + AddrW'(size);
    end
  end

  // descriptor register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      is_write      <= req_wr;
      chunk_address <= addr;
      out_req_id    <= rid;
      out_tag       <= tg;
      last          <= bad || fin;
      rejected      <= bad;
      if (bad) begin
        addr_translated <= 1'b0;
        dword_count     <= '0;
        first_be        <= '0;
        last_be         <= '0;
      end else begin
        addr_translated <= req_trans;
        dword_count     <= dw;
        first_be        <= (dw == DwW'(1)) ? be : BeFull;
        last_be         <= (dw == DwW'(1)) ? 4'h0 : be;
      end
    end
  end

`ifndef SYNTHESIS
  // a good request never steps with nothing left
  a_rem_live: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && !bad) |-> (rem != '0))
    else $error("chunk step with zero remaining");
`endif

endmodule

// ----- rtl/core/dma_request_splitter_top.sv -----
// ----------------------------------------------------------------------------
// dma_request_splitter_top
// Splits one dma read or write request into memory request descriptors of at
// most the configured read or write chunk size, one descriptor per beat.
// ----------------------------------------------------------------------------
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------
//  req      | req_valid / req_ready   | req_type .. translated
//  desc     | desc_valid / desc_ready | is_write .. rejected
//  cfg      | cfg_we (no wait)        | cfg_index, cfg_data
//
//  a request is accepted in idle, then the controller emits one descriptor
//  each time the output slot is free until the final one is out; the chunk
//  step is one length compare and one 64 bit address add
//  a rejected request yields a single descriptor with rejected and last set
//  the descriptor register sits between the two sides, so a new request is
//  taken while the final descriptor of the previous one still waits
//  desc_ready low holds the chunk counters; reset is synchronous, active high
//  and restores the chunk sizes to 512 bytes read and 128 bytes write
//
module dma_request_splitter_top #(
  parameter int unsigned MAX_LENGTH = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  // config write port
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [dmars_pkg::LenW-1:0]    cfg_data,
  // request channel
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic                          req_type,
  input  logic [dmars_pkg::LenW-1:0]    byte_length,
  input  logic [dmars_pkg::AddrW-1:0]   start_address,
  input  logic [15:0]                   req_id,
  input  logic [7:0]                    tag,
  input  logic                          translated,
  // descriptor channel
  output logic                          desc_valid,
  input  logic                          desc_ready,
  output logic                          is_write,
  output logic                          addr_translated,
  output logic [dmars_pkg::DwW-1:0]     dword_count,
  output logic [3:0]                    first_be,
  output logic [3:0]                    last_be,
  output logic [dmars_pkg::AddrW-1:0]   chunk_address,
  output logic [15:0]                   out_req_id,
  output logic [7:0]                    out_tag,
  output logic                          last,
  output logic                          rejected
);
  import dmars_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencing: idle / emit, owns the beat valid
  dmars_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .desc_valid (desc_valid),
    .desc_ready (desc_ready),
    .cmd        (cmd),
    .status     (status)
  );

  // chunk counters, config registers and descriptor register
  dmars_dp #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .status          (status),
    .req_type        (req_type),
    .byte_length     (byte_length),
    .start_address   (start_address),
    .req_id          (req_id),
    .tag             (tag),
    .translated      (translated),
    .is_write        (is_write),
    .addr_translated (addr_translated),
    .dword_count     (dword_count),
    .first_be        (first_be),
    .last_be         (last_be),
    .chunk_address   (chunk_address),
    .out_req_id      (out_req_id),
    .out_tag         (out_tag),
    .last            (last),
    .rejected        (rejected)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the dma request splitter. Requests go in on a
// valid/ready channel with random bursts and gaps, descriptors come out on a
// second channel under a rotating stall pattern. A local splitter model
// predicts every descriptor when its request beat is taken, and a monitor
// compares each descriptor beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned MaxLength  = 4096;
  localparam int unsigned CycleLimit = 1000000;
  // latency allowance after the last descriptor, before touching the registers
  localparam int unsigned SettleCycles = 4;

  // request kinds as they appear on req_type
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [12:0] len;
    logic [63:0] addr;
    logic [15:0] rid;
    logic [7:0]  tg;
    logic        xlat;
  } dma_req_t;

  typedef struct packed {
    logic        wr;
    logic        xlat;
    logic [10:0] dwords;
    logic [3:0]  fbe;
    logic [3:0]  lbe;
    logic [63:0] addr;
    logic [15:0] rid;
    logic [7:0]  tg;
    logic        fin;
    logic        rej;
  } desc_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [12:0] cfg_data;
  logic        req_valid;
  logic        req_ready;
  logic        req_type;
  logic [12:0] byte_length;
  logic [63:0] start_address;
  logic [15:0] req_id;
  logic [7:0]  tag;
  logic        translated;
  logic        desc_valid;
  logic        desc_ready;
  logic        is_write;
  logic        addr_translated;
  logic [10:0] dword_count;
  logic [3:0]  first_be;
  logic [3:0]  last_be;
  logic [63:0] chunk_address;
  logic [15:0] out_req_id;
  logic [7:0]  out_tag;
  logic        last;
  logic        rejected;

  // shadow copy of the two chunk size registers, raw 13-bit values
  logic [12:0] rd_limit;
  logic [12:0] wr_limit;

  // descriptors predicted but not yet seen on the output
  desc_t pending_descs[$];

  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned req_count;
  int unsigned desc_count;
  int unsigned reject_count;
  int unsigned setting_count;

  // sender burst control
  bit          gaps_on;
  int unsigned burst_left;

  // receiver control: rotating stall pattern plus a one-shot long hold-off
  logic [15:0] stall_pattern;
  int unsigned hold_request;
  int unsigned hold_left;

  dma_request_splitter_top #(
    .MAX_LENGTH(MaxLength)
  ) i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .req_valid       (req_valid),
    .req_ready       (req_ready),
    .req_type        (req_type),
    .byte_length     (byte_length),
    .start_address   (start_address),
    .req_id          (req_id),
    .tag             (tag),
    .translated      (translated),
    .desc_valid      (desc_valid),
    .desc_ready      (desc_ready),
    .is_write        (is_write),
    .addr_translated (addr_translated),
    .dword_count     (dword_count),
    .first_be        (first_be),
    .last_be         (last_be),
    .chunk_address   (chunk_address),
    .out_req_id      (out_req_id),
    .out_tag         (out_tag),
    .last            (last),
    .rejected        (rejected)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // run limit, far above the slowest legal run
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("timeout after %0d cycles, %0d descriptors still pending", cycle_count,
             pending_descs.size());
    $display("FAILURE");
    $finish;
  end

  // --------------------------------------------------------------------------
  // splitter model
  // --------------------------------------------------------------------------

  // chunk size in effect for a raw register value: round down to a dword
  // multiple, then clamp into 4 .. 4096
  function automatic int unsigned chunk_size_of(input logic [12:0] raw);
    int unsigned c;
    c = raw & 13'h1FFC;
    if (c < 4) c = 4;
    if (c > 4096) c = 4096;
    return c;
  endfunction

  // cut one request into its descriptors and queue them in address order
  function automatic void split_request(input dma_req_t r);
    int unsigned limit;
    int unsigned len;
    int unsigned nchunks;
    int unsigned off;
    int unsigned size;
    int unsigned dw;
    int unsigned pad;
    logic [3:0]  be;
    desc_t       d;
    limit   = chunk_size_of(r.kind == KIND_WRITE ? wr_limit : rd_limit);
    len     = r.len;
    nchunks = (len + limit - 1) / limit;
    d.wr  = r.kind;
    d.rid = r.rid;
    d.tg  = r.tg;
    if (len == 0 || len > MaxLength || nchunks > dmars_pkg::MaxDesc) begin
      // zero, oversize or too many chunks: one rejected beat
      d.xlat   = 1'b0;
      d.dwords = '0;
      d.fbe    = '0;
      d.lbe    = '0;
      d.addr   = r.addr;
      d.fin    = 1'b1;
      d.rej    = 1'b1;
      pending_descs.push_back(d);
    end else begin
      // writes never carry the translated flag
      d.xlat = (r.kind == KIND_WRITE) ? 1'b0 : r.xlat;
      d.rej  = 1'b0;
      off = 0;
      while (off < len) begin
        size = (len - off < limit) ? len - off : limit;
        dw   = (size + 3) / 4;
        pad  = dw * 4 - size;
        be   = 4'((1 << (4 - pad)) - 1);
        d.dwords = 11'(dw);
        if (dw == 1) begin
          d.fbe = be;
          d.lbe = 4'h0;
        end else begin
          d.fbe = 4'hF;
          d.lbe = be;
        end
        d.addr = r.addr + 64'(off);
        d.fin  = (off + size >= len);
        pending_descs.push_back(d);
        off += size;
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // descriptor monitor
  // --------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : check_desc
    desc_t want;
    if (!rst && desc_valid && desc_ready) begin
      desc_count++;
      if (rejected) reject_count++;
      if (pending_descs.size() == 0) begin
        error_count++;
        $display("%0t: unexpected descriptor, expected none, actual addr %0h dwords %0d",
                 $time, chunk_address, dword_count);
      end else begin
        want = pending_descs.pop_front();
        check_field("is_write", want.wr, is_write);
        check_field("addr_translated", want.xlat, addr_translated);
        check_field("dword_count", want.dwords, dword_count);
        check_field("first_be", want.fbe, first_be);
        check_field("last_be", want.lbe, last_be);
        check_field("chunk_address", want.addr, chunk_address);
        check_field("out_req_id", want.rid, out_req_id);
        check_field("out_tag", want.tg, out_tag);
        check_field("last", want.fin, last);
        check_field("rejected", want.rej, rejected);
      end
    end
  end

  // --------------------------------------------------------------------------
  // descriptor receiver: a long hold-off when asked, else the rotating pattern
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      desc_ready <= 1'b0;
      hold_left--;
    end else begin
      desc_ready    <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
    end
  end

  // --------------------------------------------------------------------------
  // shared tasks; each one is entered and left right after a rising edge
  // --------------------------------------------------------------------------

  function automatic dma_req_t request_of(input logic kind, input logic [12:0] len,
                                          input logic [63:0] addr, input logic [15:0] rid,
                                          input logic [7:0] tg, input logic xlat);
    dma_req_t r;
    r.kind = kind;
    r.len  = len;
    r.addr = addr;
    r.rid  = rid;
    r.tg   = tg;
    r.xlat = xlat;
    return r;
  endfunction

  // random request; most lengths fit in 32 chunks of the current size so
  // that most beats actually get split
  function automatic dma_req_t random_request();
    dma_req_t    r;
    int unsigned fit;
    r.kind = 1'($urandom);
    r.rid  = 16'($urandom);
    r.tg   = 8'($urandom);
    r.xlat = 1'($urandom);
    fit = 32 * chunk_size_of(r.kind == KIND_WRITE ? wr_limit : rd_limit);
    if (fit > MaxLength) fit = MaxLength;
    case ($urandom_range(0, 19))
      0:       r.len = '0;
      1:       r.len = 13'($urandom_range(MaxLength + 1, 8191));
      2, 3:    r.len = 13'($urandom_range(1, MaxLength));
      4:       r.len = 13'(fit);
      default: r.len = 13'($urandom_range(1, fit));
    endcase
    case ($urandom_range(0, 19))
      0:       r.addr = {$urandom, $urandom};                   // unaligned too
      1, 2:    r.addr = ~64'h0 - 64'($urandom_range(0, 8191)); // wraps past the top
      default: r.addr = {$urandom, $urandom} & ~64'h3;
    endcase
    return r;
  endfunction

  // offer one request beat, predict its descriptors once it is taken
  task automatic send_request(input dma_req_t r);
    req_valid     <= 1'b1;
    req_type      <= r.kind;
    byte_length   <= r.len;
    start_address <= r.addr;
    req_id        <= r.rid;
    tag           <= r.tg;
    translated    <= r.xlat;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    split_request(r);
    req_count++;
    if (gaps_on) begin
      burst_left--;
      if (burst_left == 0) begin
        req_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 8);
      end
    end
  endtask

  // stop offering, drain every predicted descriptor, then let the block settle
  task automatic wait_idle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_descs.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // register write, only ever issued with the block idle
  task automatic write_reg(input logic idx, input logic [12:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == dmars_pkg::CFG_MAX_READ) rd_limit = value;
    else wr_limit = value;
    setting_count++;
    @(posedge clk);
  endtask

  // pick a traffic shape: either random bursts and stalls or a clean stretch
  task automatic set_traffic(input bit busy);
    gaps_on    = busy;
    burst_left = $urandom_range(1, 8);
    if (busy) stall_pattern = 16'($urandom) | 16'h1;
    else stall_pattern = 16'hFFFF;
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // reset chunk sizes (512 read, 128 write): byte enables, full lengths,
  // rejects, address wrap and id/tag extremes
  task automatic test_directed_reset_sizes();
    set_traffic(1'b1);
    send_request(request_of(KIND_READ, 13'd1, 64'h0, 16'h0000, 8'h00, 1'b0));
    send_request(request_of(KIND_READ, 13'd2, 64'h1000, 16'h0001, 8'h01, 1'b1));
    send_request(request_of(KIND_READ, 13'd3, 64'h2000, 16'h8000, 8'h80, 1'b1));
    send_request(request_of(KIND_READ, 13'd4, 64'h3000, 16'h5555, 8'h55, 1'b0));
    send_request(request_of(KIND_READ, 13'd5, 64'h4000, 16'hAAAA, 8'hAA, 1'b1));
    // one full read, 8 chunks of 512
    send_request(request_of(KIND_READ, 13'd4096, 64'h8000_0000, 16'h1234, 8'h12, 1'b1));
    // the longest split: 32 write chunks of 128, translated ignored
    send_request(request_of(KIND_WRITE, 13'd4096, 64'h1_0000_0000, 16'hFFFF, 8'hFF, 1'b1));
    send_request(request_of(KIND_WRITE, 13'd130, 64'h40, 16'h0F0F, 8'h0F, 1'b0));
    send_request(request_of(KIND_WRITE, 13'd4095, 64'h7FFF_FFFF_FFFF_F000, 16'h3C3C,
                            8'h3C, 1'b0));
    send_request(request_of(KIND_READ, 13'd513, 64'hDEAD_BEEF_0000_0000, 16'h4321,
                            8'h43, 1'b1));
    // bad lengths
    send_request(request_of(KIND_READ, 13'd0, 64'hCAFE_0000, 16'hBEEF, 8'hEF, 1'b1));
    send_request(request_of(KIND_WRITE, 13'd4097, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000,
                            8'h00, 1'b0));
    send_request(request_of(KIND_READ, 13'd8191, 64'h5555_5555_5555_5555, 16'hFFFF,
                            8'hFF, 1'b1));
    // chunk addresses wrap past the top of the address space
    send_request(request_of(KIND_READ, 13'd1024, 64'hFFFF_FFFF_FFFF_FE00, 16'h7777,
                            8'h77, 1'b1));
    send_request(request_of(KIND_WRITE, 13'd256, 64'hFFFF_FFFF_FFFF_FFC0, 16'hFFFF,
                            8'hFF, 1'b0));
    // address off a dword boundary is passed through as is
    send_request(request_of(KIND_READ, 13'd7, 64'hAAAA_AAAA_AAAA_AAAB, 16'h1111,
                            8'h11, 1'b0));
    wait_idle();
  endtask

  // register extremes and odd values that get rounded or clamped
  task automatic test_register_extremes();
    set_traffic(1'b0);
    write_reg(dmars_pkg::CFG_MAX_READ, 13'd4);
    write_reg(dmars_pkg::CFG_MAX_WRITE, 13'd4096);
    send_request(request_of(KIND_READ, 13'd128, 64'h100, 16'h0101, 8'h01, 1'b1));
    send_request(request_of(KIND_READ, 13'd129, 64'h200, 16'h0202, 8'h02, 1'b1));
    send_request(request_of(KIND_READ, 13'd3, 64'h300, 16'h0303, 8'h03, 1'b0));
    send_request(request_of(KIND_WRITE, 13'd4096, 64'h400, 16'h0404, 8'h04, 1'b1));
    send_request(request_of(KIND_WRITE, 13'd4093, 64'h500, 16'h0505, 8'h05, 1'b0));
    wait_idle();
    // zero rounds up to 4, all ones clamps to 4096
    write_reg(dmars_pkg::CFG_MAX_READ, 13'd0);
    write_reg(dmars_pkg::CFG_MAX_WRITE, 13'h1FFF);
    set_traffic(1'b1);
    send_request(request_of(KIND_READ, 13'd8, 64'h600, 16'h0606, 8'h06, 1'b1));
    send_request(request_of(KIND_WRITE, 13'd4096, 64'h700, 16'h0707, 8'h07, 1'b0));
    wait_idle();
    // 7 rounds down to 4, just over 4096 rounds down to 4096
    write_reg(dmars_pkg::CFG_MAX_WRITE, 13'd7);
    write_reg(dmars_pkg::CFG_MAX_READ, 13'd4097);
    send_request(request_of(KIND_WRITE, 13'd5, 64'h800, 16'h0808, 8'h08, 1'b0));
    send_request(request_of(KIND_READ, 13'd4096, 64'h900, 16'h0909, 8'h09, 1'b1));
    send_request(request_of(KIND_WRITE, 13'd130, 64'hA00, 16'h0A0A, 8'h0A, 1'b0));
    wait_idle();
    // a value that is not a dword multiple, rounded down to 512
    write_reg(dmars_pkg::CFG_MAX_READ, 13'd514);
    send_request(request_of(KIND_READ, 13'd1029, 64'hB00, 16'h0B0B, 8'h0B, 1'b1));
    wait_idle();
  endtask

  // raw register value for one random phase, extremes included
  function automatic logic [12:0] random_limit();
    case ($urandom_range(0, 5))
      0:       return 13'd4;
      1:       return 13'd4096;
      2:       return 13'($urandom_range(1, 64) * 4);
      3:       return 13'($urandom_range(1, 1024) * 4);
      4:       return 13'($urandom_range(0, 8191));
      default: return ($urandom_range(0, 1) != 0) ? 13'd512 : 13'd128;
    endcase
  endfunction

  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned n;
    for (phase = 0; phase < 6; phase++) begin
      write_reg(dmars_pkg::CFG_MAX_READ, random_limit());
      write_reg(dmars_pkg::CFG_MAX_WRITE, random_limit());
      // every other phase runs without gaps or stalls
      set_traffic(phase % 2 == 0);
      for (n = 0; n < 35; n++) send_request(random_request());
      wait_idle();
    end
  endtask

  // hold the descriptor side off for a long stretch while long writes keep
  // coming, so the splitter backs up and drops req_ready
  task automatic test_output_backpressure();
    int unsigned n;
    write_reg(dmars_pkg::CFG_MAX_WRITE, 13'd128);
    write_reg(dmars_pkg::CFG_MAX_READ, 13'd256);
    set_traffic(1'b0);
    hold_request = 400;
    for (n = 0; n < 24; n++) begin
      if (n % 3 == 2) send_request(random_request());
      else send_request(request_of(KIND_WRITE, 13'd4096, {$urandom, $urandom} & ~64'h3,
                                   16'($urandom), 8'($urandom), 1'b1));
    end
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = 1'b0;
    cfg_data      = '0;
    req_valid     = 1'b0;
    req_type      = 1'b0;
    byte_length   = '0;
    start_address = '0;
    req_id        = '0;
    tag           = '0;
    translated    = 1'b0;
    desc_ready    = 1'b0;
    stall_pattern = 16'hFFFF;
    hold_request  = 0;
    hold_left     = 0;
    cycle_count   = 0;
    error_count   = 0;
    req_count     = 0;
    desc_count    = 0;
    reject_count  = 0;
    setting_count = 0;
    gaps_on       = 1'b0;
    burst_left    = 1;
    rd_limit      = 13'd512;
    wr_limit      = 13'd128;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_reset_sizes();
    test_register_extremes();
    test_random_traffic();
    test_output_backpressure();

    $display("checked %0d requests split into %0d descriptors, %0d of them rejects",
             req_count, desc_count, reject_count);
    $display("covered %0d register writes, long output hold-off, %0d cycles",
             setting_count, cycle_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", error_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
